// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL (included by fp8_block_scale_dequant).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hdl/fp8bsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fp8bsd_pkg
// Constants and types for the FP8 block-scale dequantizer.
// ---------------------------------------------------------------------------
package fp8bsd_pkg;

  localparam logic [15:0] Bf16Nan = 16'h7FC0;
  localparam logic [15:0] Bf16Inf = 16'h7F80;

  typedef enum logic {
    CFG_WEIGHT_FORMAT = 1'b0,
    CFG_SCALE_FORMAT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_FIN = 2'd0,
    CLS_INF = 2'd1,
    CLS_NAN = 2'd2
  } cls_e;

  // Product class after special-case resolution.
  typedef enum logic [1:0] {
    SPC_FIN  = 2'd0,
    SPC_ZERO = 2'd1,
    SPC_INF  = 2'd2,
    SPC_NAN  = 2'd3
  } spc_e;

endpackage
`default_nettype wire

// ===== hdl/fp8_block_scale_dequant.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fp8_block_scale_dequant
// FP8 (E4M3FN / E5M2) weight times tile scale (E8M0 or BF16) to BF16.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per weight; tdata = {scale_code[15:0], weight_code[7:0]}.
//   m_axis: one beat per result; tdata = result_bf16.
//   cfg: cfg_we_i / cfg_idx_i / cfg_wdata_i, written while idle.
// Pipeline: decode -> 8x4 multiply -> normalize -> round/pack, four
//   register stages from accept to m_axis_tvalid.
// Throughput: one beat per cycle while the output register is empty or drained.
// Stall: all stages advance together on a global enable; tready is high
//   whenever the output register is empty or being drained, so a full
//   pipeline holds every beat with nothing lost or repeated.
// Reset: valid bits clear, weight_format = E4M3FN, scale_format = E8M0.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module fp8_block_scale_dequant (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] weight_code, [23:8] scale_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [15:0] result_bf16
);
  import fp8bsd_pkg::*;

  logic wfmt_q, sfmt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wfmt_q <= 1'b0;
      sfmt_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WEIGHT_FORMAT: wfmt_q <= cfg_wdata_i;
        CFG_SCALE_FORMAT:  sfmt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [3:0] vld_q;
  logic       adv;
  assign adv           = !vld_q[3] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[2:0], s_axis_tvalid};
  end

  // ---- stage 1: decode both operands ------------------------------------
  logic [7:0]  wc;
  logic [15:0] sb;
  logic [3:0]  wm_d;  // weight mag
  logic signed [9:0] we_d;
  cls_e        wc_d, sc_d;
  logic [7:0]  sm_d;
  logic signed [9:0] se_d;

  always_comb begin
    wc = s_axis_tdata[7:0];
    sb = sfmt_q ? ((s_axis_tdata[15:8] == 8'd0) ? 16'h0040 : {1'b0, s_axis_tdata[15:8], 7'd0})
                : s_axis_tdata[23:8];
    wc_d = CLS_FIN;
    if (!wfmt_q) begin
      if (wc[6:3] == 4'hF && wc[2:0] == 3'h7) begin
        wc_d = CLS_NAN; wm_d = '0; we_d = '0;
      end else if (wc[6:3] == 4'h0) begin
        wm_d = {1'b0, wc[2:0]}; we_d = -10'sd9;
      end else begin
        wm_d = {1'b1, wc[2:0]}; we_d = $signed({6'd0, wc[6:3]}) - 10'sd10;
      end
    end else begin
      if (wc[6:2] == 5'h1F) begin
        wc_d = (wc[1:0] == 2'd0) ? CLS_INF : CLS_NAN; wm_d = '0; we_d = '0;
      end else if (wc[6:2] == 5'h0) begin
        wm_d = {2'b0, wc[1:0]}; we_d = -10'sd16;
      end else begin
        wm_d = {2'b01, wc[1:0]}; we_d = $signed({5'd0, wc[6:2]}) - 10'sd17;
      end
    end
    sc_d = CLS_FIN;
    if (sb[14:7] == 8'hFF) begin
      sc_d = (sb[6:0] == 7'd0) ? CLS_INF : CLS_NAN; sm_d = '0; se_d = '0;
    end else if (sb[14:7] == 8'h00) begin
      sm_d = {1'b0, sb[6:0]}; se_d = -10'sd133;
    end else begin
      sm_d = {1'b1, sb[6:0]}; se_d = $signed({2'd0, sb[14:7]}) - 10'sd134;
    end
  end

  logic [3:0] wm1_q; logic [7:0] sm1_q; logic signed [9:0] ex1_q;
  cls_e wc1_q, sc1_q; logic sg1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wm1_q <= wm_d; sm1_q <= sm_d; ex1_q <= we_d + se_d;
      wc1_q <= wc_d; sc1_q <= sc_d; sg1_q <= wc[7] ^ sb[15];
    end
  end

  // ---- stage 2: multiply and resolve specials ---------------------------
  spc_e spc_d;
  always_comb begin
    if (wc1_q == CLS_NAN || sc1_q == CLS_NAN) spc_d = SPC_NAN;
    else if (wc1_q == CLS_INF || sc1_q == CLS_INF)
      spc_d = ((wc1_q == CLS_FIN && wm1_q == 0) || (sc1_q == CLS_FIN && sm1_q == 0))
              ? SPC_NAN : SPC_INF;
    else if (wm1_q == 0 || sm1_q == 0) spc_d = SPC_ZERO;
    else spc_d = SPC_FIN;
  end

  logic [11:0] pr2_q; logic signed [9:0] ex2_q; spc_e sp2_q; logic sg2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr2_q <= {4'd0, sm1_q} * {8'd0, wm1_q};
      ex2_q <= ex1_q; sp2_q <= spc_d; sg2_q <= sg1_q;
    end
  end

  // ---- stage 3: find leading one, choose shift amount --------------------
  logic [3:0] p_d;
  logic signed [10:0] q_d, sh_d;
  always_comb begin
    p_d = '0;
    for (int i = 0; i < 12; i++) if (pr2_q[i]) p_d = 4'(i);
    q_d = ($signed({7'd0, p_d}) + 11'(ex2_q) >= -11'sd126)
          ? $signed({7'd0, p_d}) + 11'(ex2_q) - 11'sd7 : -11'sd133;
    sh_d = q_d - 11'(ex2_q);
  end

  logic [11:0] pr3_q; logic signed [10:0] q3_q, sh3_q; spc_e sp3_q; logic sg3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr3_q <= pr2_q; q3_q <= q_d; sh3_q <= sh_d; sp3_q <= sp2_q; sg3_q <= sg2_q;
    end
  end

  // ---- stage 4: shift, round, pack ---------------------------------------
  // Left shift (at most 7) when the shift is not positive (a normal result
  // under 8 significant bits); otherwise right shift, nearest-even rounding.
  logic [19:0] r_d;
  logic [11:0] rem, half;
  logic [15:0] mag_d, res_d;
  logic [3:0]  s4;
  logic signed [11:0] eb;
  always_comb begin
    rem = '0; half = '0; s4 = '0;
    if (sh3_q <= 0) begin
      r_d = {8'd0, pr3_q} << 5'(-sh3_q);
    end else if (sh3_q > 12) begin
      r_d = '0;
    end else begin
      s4 = 4'(sh3_q);
      r_d = {8'd0, pr3_q >> s4};
      rem = pr3_q & ((12'd1 << s4) - 12'd1);
      half = 12'd1 << (s4 - 4'd1);
      if (rem > half || (rem == half && r_d[0])) r_d = r_d + 20'd1;
    end
    eb = 12'(q3_q) + 12'sd134;
    if (q3_q == -11'sd133 && r_d <= 20'd128) mag_d = r_d[15:0];
    else if (eb >= 12'sd255) mag_d = Bf16Inf;
    else mag_d = 16'({eb[7:0], 7'd0}) + r_d[15:0] - 16'd128;
    if (mag_d >= Bf16Inf) mag_d = Bf16Inf;
    case (sp3_q)
      SPC_FIN:  res_d = {sg3_q, mag_d[14:0]};
      SPC_ZERO: res_d = {sg3_q, 15'd0};
      SPC_INF:  res_d = {sg3_q, Bf16Inf[14:0]};
      default:  res_d = Bf16Nan;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) m_axis_tdata <= res_d;
  end

  `ASSERT_CLK(a_stall_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "output changed under stall")
  `ASSERT_CLK(a_ready, (!m_axis_tvalid) |-> s_axis_tready, "not ready with empty output")
  `ASSERT_NEVER(a_nan_sign, m_axis_tvalid && m_axis_tdata[15] && m_axis_tdata[14:6] == 9'h1FF, "negative NaN produced")

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the FP8 block-scale dequantizer: directed table
// of corner beats, then random beats under random idling on both sides
// (bar one phase); results checked vs. known rows or a BF16 product model.
// ---------------------------------------------------------------------------
module tb;
  import fp8bsd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom  = 1950;
  localparam int unsigned DrainWait  = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] weight_code, [23:8] scale_code
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] result_bf16

  fp8_block_scale_dequant i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Local copy of the two format registers.
  logic wfmt_q;
  logic sfmt_q;

  logic [15:0] expected_bf16_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          idle_ok;       // false during the no-idling stretch

  // Unpacked operand: value = mag * 2^ex, or inf/nan.
  typedef struct {
    cls_e        cls;
    logic        sgn;
    int unsigned mag;
    int          ex;
  } opnd_t;

  function automatic opnd_t unpack_fp8(logic [7:0] c, logic fmt);
    opnd_t o;
    o.sgn = c[7];
    o.cls = CLS_FIN;
    o.mag = 0;
    o.ex  = 0;
    if (!fmt) begin
      if (c[6:0] == 7'h7F) o.cls = CLS_NAN;
      else if (c[6:3] == 0) begin
        o.mag = c[2:0]; o.ex = -9;
      end else begin
        o.mag = 8 + c[2:0]; o.ex = int'(c[6:3]) - 10;
      end
    end else begin
      if (c[6:2] == 5'h1F) o.cls = (c[1:0] == 0) ? CLS_INF : CLS_NAN;
      else if (c[6:2] == 0) begin
        o.mag = c[1:0]; o.ex = -16;
      end else begin
        o.mag = 4 + c[1:0]; o.ex = int'(c[6:2]) - 17;
      end
    end
    return o;
  endfunction

  function automatic opnd_t unpack_bf16(logic [15:0] b);
    opnd_t o;
    o.sgn = b[15];
    o.cls = CLS_FIN;
    o.mag = 0;
    o.ex  = 0;
    if (b[14:7] == 8'hFF) o.cls = (b[6:0] == 0) ? CLS_INF : CLS_NAN;
    else if (b[14:7] == 0) begin
      o.mag = b[6:0]; o.ex = -133;
    end else begin
      o.mag = 128 + b[6:0]; o.ex = int'(b[14:7]) - 134;
    end
    return o;
  endfunction

  // Nearest-even rounding of sig * 2^ex to a BF16 magnitude, subnormals kept.
  function automatic logic [15:0] round_mag(int unsigned sig, int ex);
    int          msb;
    int          lsb_ex;
    int          sh;
    int unsigned r;
    int unsigned rem;
    int unsigned half;
    int unsigned bits;
    msb = 0;
    while (msb < 31 && (sig >> (msb + 1)) != 0) msb++;
    lsb_ex = (msb + ex >= -126) ? (msb + ex - 7) : -133;
    sh = lsb_ex - ex;
    if (sh <= 0) r = sig << (-sh);
    else if (sh > 31) r = 0;
    else begin
      rem  = sig & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      r    = sig >> sh;
      if (rem > half || (rem == half && r[0])) r++;
    end
    if (lsb_ex == -133 && r <= 128) bits = r;
    else if (lsb_ex + 134 >= 255) bits = Bf16Inf;
    else bits = ((lsb_ex + 134) << 7) + r - 128;
    if (bits >= Bf16Inf) bits = Bf16Inf;
    return bits[15:0];
  endfunction

  function automatic logic [15:0] dequant_bf16(logic [7:0] wc, logic [15:0] sc);
    logic [15:0] sbits;
    opnd_t       w;
    opnd_t       s;
    logic [15:0] sgn;
    bit          has_zero;
    if (!sfmt_q) sbits = sc;
    else if (sc[7:0] == 0) sbits = 16'h0040;   // 2^-127 is subnormal
    else sbits = {1'b0, sc[7:0], 7'h0};        // code 255 lands on infinity
    w = unpack_fp8(wc, wfmt_q);
    s = unpack_bf16(sbits);
    sgn = {w.sgn ^ s.sgn, 15'h0};
    has_zero = (w.cls == CLS_FIN && w.mag == 0) || (s.cls == CLS_FIN && s.mag == 0);
    if (w.cls == CLS_NAN || s.cls == CLS_NAN) return Bf16Nan;
    if (w.cls == CLS_INF || s.cls == CLS_INF) return has_zero ? Bf16Nan : (sgn | Bf16Inf);
    if (has_zero) return sgn;
    return sgn | round_mag(w.mag * s.mag, w.ex + s.ex);
  endfunction

  // Directed rows: exp_bf16 is checked when known is set, else predicted.
  typedef struct {
    logic        wfmt;
    logic        sfmt;
    logic [7:0]  wc;
    logic [15:0] sc;
    bit          known;
    logic [15:0] exp_bf16;
  } row_t;

  localparam int NumRows = 22;
  row_t rows[NumRows] = '{
    // E4M3FN weights, E8M0 scales (reset setting)
    '{1'b0, 1'b1, 8'h38, 16'h007F, 1'b1, 16'h3F80},  // 1.0 * 1
    '{1'b0, 1'b1, 8'h7F, 16'h007F, 1'b1, Bf16Nan},   // E4M3 NaN
    '{1'b0, 1'b1, 8'hFF, 16'h0080, 1'b1, Bf16Nan},   // negative NaN pattern
    '{1'b0, 1'b1, 8'h7E, 16'h007F, 1'b0, 16'h0000},  // E4M3 max 448
    '{1'b0, 1'b1, 8'h01, 16'h0000, 1'b0, 16'h0000},  // min subnormal * 2^-127
    '{1'b0, 1'b1, 8'h38, 16'hFF00, 1'b1, 16'h0040},  // code 0, upper byte ignored
    '{1'b0, 1'b1, 8'hB8, 16'h00FF, 1'b1, 16'hFF80},  // -1 * inf
    '{1'b0, 1'b1, 8'h00, 16'h00FF, 1'b1, Bf16Nan},   // 0 * inf
    '{1'b0, 1'b1, 8'h80, 16'h0050, 1'b1, 16'h8000},  // -0 product
    '{1'b0, 1'b1, 8'h7E, 16'h00FE, 1'b1, Bf16Inf},   // overflow
    '{1'b0, 1'b1, 8'h09, 16'h0001, 1'b0, 16'h0000},  // deep subnormal rounding
    // E5M2 weights
    '{1'b1, 1'b1, 8'h7C, 16'h007F, 1'b1, Bf16Inf},   // +inf weight
    '{1'b1, 1'b1, 8'hFC, 16'h0000, 1'b1, 16'hFF80},  // -inf * tiny
    '{1'b1, 1'b1, 8'h7D, 16'h007F, 1'b1, Bf16Nan},   // E5M2 NaN
    '{1'b1, 1'b1, 8'h7B, 16'h0085, 1'b0, 16'h0000},  // E5M2 max
    '{1'b1, 1'b1, 8'h01, 16'h0010, 1'b0, 16'h0000},
    // BF16 scales
    '{1'b1, 1'b0, 8'h3C, 16'hFFFF, 1'b1, Bf16Nan},   // NaN scale
    '{1'b1, 1'b0, 8'h00, 16'hFF80, 1'b1, Bf16Nan},   // 0 * -inf
    '{1'b1, 1'b0, 8'h3C, 16'h7F7F, 1'b1, 16'h7F7F},  // 1.0 * max
    '{1'b0, 1'b0, 8'h7E, 16'h7F7F, 1'b1, Bf16Inf},   // overflow
    '{1'b0, 1'b0, 8'hB9, 16'h0001, 1'b0, 16'h0000},  // subnormal scale
    '{1'b0, 1'b0, 8'h38, 16'h8000, 1'b1, 16'h8000}   // 1 * -0
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random backpressure, check each accepted beat in order.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= idle_ok ? ($urandom_range(99) >= 32) : 1'b1;
  end

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bf16_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = expected_bf16_q.pop_front();
        if (m_axis_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result_bf16 mismatch: expected %h got %h", want, m_axis_tdata);
        end
      end
    end
  end

  // Drops tvalid, then waits for every expected beat plus a quiet gap.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_bf16_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_WEIGHT_FORMAT) wfmt_q = val;
    else sfmt_q = val;
  endtask

  // Drive one beat from a falling edge; returns at the falling edge after
  // accept with tvalid still high, so beats can follow back to back.
  task automatic send_beat(logic [7:0] wc, logic [15:0] sc, bit known, logic [15:0] want);
    if (idle_ok) begin
      while ($urandom_range(99) < 32) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sc, wc};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_bf16_q.push_back(known ? want : dequant_bf16(wc, sc));
    @(negedge clk_i);
  endtask

  // Random scale: mostly finite codes, with NaN/inf patterns mixed in.
  function automatic logic [15:0] rand_scale();
    if (sfmt_q) return $urandom_range(99) < 80 ? 16'($urandom_range(100, 154))
                                               | 16'($urandom_range(255) << 8)
                                               : 16'($urandom_range(65535));
    return $urandom_range(99) < 70 ? {1'($urandom_range(1)), 8'($urandom_range(96, 160)),
                                      7'($urandom_range(127))}
                                   : 16'($urandom_range(65535));
  endfunction

  initial begin
    logic wf;
    logic sf;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_WEIGHT_FORMAT;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    idle_ok       = 1'b1;
    wfmt_q        = 1'b0;   // reset values
    sfmt_q        = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table; first rows run on reset settings.
    foreach (rows[i]) begin
      if (rows[i].wfmt != wfmt_q || rows[i].sfmt != sfmt_q) begin
        wait_drained();
        if (rows[i].wfmt != wfmt_q) write_cfg(CFG_WEIGHT_FORMAT, rows[i].wfmt);
        if (rows[i].sfmt != sfmt_q) write_cfg(CFG_SCALE_FORMAT, rows[i].sfmt);
      end
      send_beat(rows[i].wc, rows[i].sc, rows[i].known, rows[i].exp_bf16);
    end

    // Six random phases over the four settings; the third runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      wf = ph[0];
      sf = ph[1] ^ ph[2];
      wait_drained();
      write_cfg(CFG_WEIGHT_FORMAT, wf);
      write_cfg(CFG_SCALE_FORMAT, sf);
      idle_ok = (ph != 2);
      for (int n = 0; n < NumRandom / 6; n++) begin
        send_beat(8'($urandom_range(255)), rand_scale(), 1'b0, 16'h0);
        if (n == 150) wait_drained();   // sender holds off until all results are back
      end
      idle_ok = 1'b1;
    end

    wait_drained();
    if (mismatches == 0 && expected_bf16_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
